// ===== hdl/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Assertion macros used by the checker module of the semaphore table.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the active-low reset is low.
`define SCT_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Concurrent assertion on clk, disabled while arst_n is low.
`define SCT_ASSERT(lbl, prop, msg) \
	`SCT_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ===== hdl/sct_pkg.sv =====
// ============================================================================
// sct_pkg
// Sizes, operation and status codes, and the slot record layout of the
// counting semaphore table.
// ============================================================================
package sct_pkg;

	localparam int SEM_COUNT   = 16;
	localparam int QUEUE_DEPTH = 8;

	localparam int OP_W       = 3;
	localparam int KEY_W      = 64;
	localparam int CNT_W      = 16;
	localparam int IDX_W      = 8;
	localparam int PID_W      = 8;
	localparam int STAT_W     = 3;
	localparam int SLOT_OUT_W = 4;
	localparam int REF_W      = 8;

	localparam int SLOT_W    = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
	localparam int HEAD_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LEN_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int POS_W     = LEN_W + 1;
	localparam int PID_DEPTH = SEM_COUNT * QUEUE_DEPTH;
	localparam int PID_AW    = (PID_DEPTH > 1) ? $clog2(PID_DEPTH) : 1;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_OPEN  = 3'd0,
		OP_CLOSE = 3'd1,
		OP_WAIT  = 3'd2,
		OP_RETRY = 3'd3,
		OP_POST  = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK          = 3'd0,
		ST_BLOCKED     = 3'd1,
		ST_BAD_INDEX   = 3'd2,
		ST_QUEUE_FULL  = 3'd3,
		ST_NO_SLOT     = 3'd4,
		ST_NOT_FOUND   = 3'd5,
		ST_NOT_GRANTED = 3'd6
	} status_t;

	// One entry of the slot record memory.
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [REF_W-1:0]  refs;
		logic [HEAD_W-1:0] head;
		logic [LEN_W-1:0]  len;
	} rec_t;

endpackage

// ===== hdl/counting_semaphore_table.sv =====
// ============================================================================
// counting_semaphore_table
// A table of counting semaphores with per-semaphore FIFO wait queues,
// looked up by name key or by slot index.
// ============================================================================
// Every command passes through a lookup cycle, in which the name key
// is matched against all allocated slots at once and the slot record memory
// is read, then a read-modify-write cycle that updates the record. start is
// taken on any edge where busy is low, so a new command may be issued in the
// cycle right after busy drops, during the RMW cycle of the previous one. The
// result is registered at the end of the RMW cycle and appears on done and
// the result ports; it is shown for exactly one cycle. The receiver cannot
// stall it, so it must take each result in the cycle it is shown. The set of
// commands in flight never overlaps on the memories, so no forwarding is
// needed. There is no clearing pass after reset: the block is ready at once,
// and only the free flags, the sequencer state and done are reset.
// ============================================================================
module counting_semaphore_table import sct_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [OP_W-1:0]       operation,
	input  logic [KEY_W-1:0]      name_key,
	input  logic [CNT_W-1:0]      init_value,
	input  logic [IDX_W-1:0]      sem_index,
	input  logic [PID_W-1:0]      pid,
	output logic                  done,
	output logic [STAT_W-1:0]     status,
	output logic [SLOT_OUT_W-1:0] slot,
	output logic                  wake_valid,
	output logic [PID_W-1:0]      wake_pid
);

	// Sequencer: idle, lookup, and read-modify-write.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_RMW  = 3'b100
	} state_t;

	state_t state_q, state_nx;

	logic accept;
	logic rmw;

	// Command captured at the transfer; it holds through the whole command
	// because the next transfer can only happen at the end of the RMW cycle.
	logic [OP_W-1:0]  op_s1;
	logic [KEY_W-1:0] key_s1;
	logic [CNT_W-1:0] init_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [PID_W-1:0] pid_s1;

	// Name store: one key register and one free flag per slot, matched in
	// parallel like a small CAM.
	logic [KEY_W-1:0]     key_q [SEM_COUNT];
	logic [SEM_COUNT-1:0] free_q;
	logic [SEM_COUNT-1:0] hit_vec;

	logic              hit_any, free_any;
	logic [SLOT_W-1:0] hit_idx, free_idx;

	// Lookup-stage decisions.
	logic [SLOT_W-1:0] tgt;
	logic              tgt_found, tgt_new, tgt_bad;

	logic [SLOT_W-1:0] slot_s2;
	logic              found_s2, new_s2, bad_s2;

	// Slot record memory (count, references, queue head and length).
	rec_t rec_mem [SEM_COUNT];
	rec_t rec_rd_s2;
	rec_t rec_wr;
	logic rec_we;

	// Wait queue memory: QUEUE_DEPTH pids per slot, stored back to back.
	logic [PID_W-1:0]  pid_mem [PID_DEPTH];
	logic [PID_AW-1:0] pid_base, pid_addr;
	logic              pid_we;

	logic [POS_W-1:0]  pos_sum, pos_wrap, head_inc;
	logic [HEAD_W-1:0] tail_pos, head_nx;

	logic key_we, set_free, clr_free;

	status_t               st;
	logic [SLOT_OUT_W-1:0] slot_res;
	logic                  wv;

	// Result stage.
	logic                  done_s3;
	logic [STAT_W-1:0]     status_s3;
	logic [SLOT_OUT_W-1:0] slot_s3;
	logic                  wv_s3;
	logic [PID_W-1:0]      pid_rd_s3;

	// ------------------------------------------------------------------
	// Handshake and sequencer
	// ------------------------------------------------------------------
	assign busy   = (state_q == S_LOOK);
	assign accept = start & ~busy;
	assign rmw    = (state_q == S_RMW);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:  state_nx = start ? S_LOOK : S_IDLE;
			S_LOOK:  state_nx = S_RMW;
			S_RMW:   state_nx = start ? S_LOOK : S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			key_s1  <= name_key;
			init_s1 <= init_value;
			idx_s1  <= sem_index;
			pid_s1  <= pid;
		end
	end

	// ------------------------------------------------------------------
	// Lookup cycle: match the key against every allocated slot and find
	// the lowest free slot; the lowest matching index wins.
	// ------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < SEM_COUNT; i++) begin
			hit_vec[i] = ~free_q[i] & (key_q[i] == key_s1);
		end
	end

	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SEM_COUNT - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_any = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (free_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		tgt       = idx_s1[SLOT_W-1:0];
		tgt_found = 1'b1;
		tgt_new   = 1'b0;
		tgt_bad   = (idx_s1 >= IDX_W'(SEM_COUNT));
		case (op_s1)
			OP_OPEN: begin
				tgt       = hit_any ? hit_idx : free_idx;
				tgt_found = hit_any | free_any;
				tgt_new   = ~hit_any;
			end
			OP_CLOSE: begin
				tgt       = hit_idx;
				tgt_found = hit_any;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOOK) begin
			slot_s2   <= tgt;
			found_s2  <= tgt_found;
			new_s2    <= tgt_new;
			bad_s2    <= tgt_bad;
			rec_rd_s2 <= rec_mem[tgt];
		end
		if (rec_we) begin
			rec_mem[slot_s2] <= rec_wr;
		end
	end

	// ------------------------------------------------------------------
	// Read-modify-write cycle
	// ------------------------------------------------------------------
	// Tail position for a new waiter and the next head after a wake, both
	// wrapped at the queue depth.
	assign pos_sum  = POS_W'(rec_rd_s2.head) + POS_W'(rec_rd_s2.len);
	assign pos_wrap = (pos_sum >= POS_W'(QUEUE_DEPTH)) ? pos_sum - POS_W'(QUEUE_DEPTH)
	                                                   : pos_sum;
	assign tail_pos = pos_wrap[HEAD_W-1:0];
	assign head_inc = POS_W'(rec_rd_s2.head) + POS_W'(1);
	assign head_nx  = (head_inc >= POS_W'(QUEUE_DEPTH)) ? '0 : head_inc[HEAD_W-1:0];

	assign pid_base = PID_AW'(slot_s2) * PID_AW'(QUEUE_DEPTH);
	assign pid_addr = pid_base + PID_AW'((op_s1 == OP_POST) ? rec_rd_s2.head : tail_pos);

	always_comb begin
		rec_wr   = rec_rd_s2;
		rec_we   = 1'b0;
		key_we   = 1'b0;
		set_free = 1'b0;
		clr_free = 1'b0;
		pid_we   = 1'b0;
		st       = ST_OK;
		slot_res = '0;
		wv       = 1'b0;
		if (rmw) begin
			case (op_s1)
				OP_OPEN: begin
					if (!found_s2) begin
						st = ST_NO_SLOT;
					end else begin
						slot_res = SLOT_OUT_W'(slot_s2);
						rec_we   = 1'b1;
						if (new_s2) begin
							rec_wr.count = init_s1;
							rec_wr.refs  = REF_W'(1);
							rec_wr.head  = '0;
							rec_wr.len   = '0;
							key_we       = 1'b1;
							clr_free     = 1'b1;
						end else if (rec_rd_s2.refs != REF_MAX) begin
							rec_wr.refs = rec_rd_s2.refs + REF_W'(1);
						end
					end
				end
				OP_CLOSE: begin
					if (!found_s2) begin
						st = ST_NOT_FOUND;
					end else begin
						rec_we = 1'b1;
						if (rec_rd_s2.refs <= REF_W'(1)) begin
							rec_wr.refs = '0;
							set_free    = 1'b1;
						end else begin
							rec_wr.refs = rec_rd_s2.refs - REF_W'(1);
						end
					end
				end
				OP_WAIT: begin
					if (bad_s2) begin
						st = ST_BAD_INDEX;
					end else if (rec_rd_s2.count != '0) begin
						rec_we       = 1'b1;
						rec_wr.count = rec_rd_s2.count - CNT_W'(1);
					end else if (rec_rd_s2.len >= LEN_W'(QUEUE_DEPTH)) begin
						st = ST_QUEUE_FULL;
					end else begin
						rec_we     = 1'b1;
						pid_we     = 1'b1;
						rec_wr.len = rec_rd_s2.len + LEN_W'(1);
						st         = ST_BLOCKED;
					end
				end
				OP_RETRY: begin
					if (bad_s2) begin
						st = ST_BAD_INDEX;
					end else if (rec_rd_s2.count != '0) begin
						rec_we       = 1'b1;
						rec_wr.count = rec_rd_s2.count - CNT_W'(1);
					end else begin
						st = ST_NOT_GRANTED;
					end
				end
				OP_POST: begin
					if (bad_s2) begin
						st = ST_BAD_INDEX;
					end else begin
						rec_we = 1'b1;
						if (rec_rd_s2.count != CNT_MAX) begin
							rec_wr.count = rec_rd_s2.count + CNT_W'(1);
						end
						if (rec_rd_s2.len != '0) begin
							wv          = 1'b1;
							rec_wr.head = head_nx;
							rec_wr.len  = rec_rd_s2.len - LEN_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The woken pid is read here and registered so that it shows up with the result.
	always_ff @(posedge clk) begin
		if (pid_we) begin
			pid_mem[pid_addr] <= pid_s1;
		end
		if (rmw) begin
			pid_rd_s3 <= pid_mem[pid_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_q[slot_s2] <= key_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else if (set_free) begin
			free_q[slot_s2] <= 1'b1;
		end else if (clr_free) begin
			free_q[slot_s2] <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Result stage: shown for one cycle after the RMW cycle.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= rmw;
		end
	end

	always_ff @(posedge clk) begin
		if (rmw) begin
			status_s3 <= st;
			slot_s3   <= slot_res;
			wv_s3     <= wv;
		end
	end

	assign done       = done_s3;
	assign status     = status_s3;
	assign slot       = slot_s3;
	assign wake_valid = done_s3 & wv_s3;
	assign wake_pid   = wake_valid ? pid_rd_s3 : '0;

endmodule

// ===== hdl/sct_checker.sv =====
// ============================================================================
// sct_checker
// Port-level checks of command timing and result framing for the
// counting semaphore table.
// ============================================================================
`include "assert_macros.svh"

module sct_checker import sct_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [STAT_W-1:0] status,
	input logic              wake_valid
);

	// Every transfer is followed by its result on done.
	`SCT_ASSERT(a_result_latency, (start && !busy) |-> ##3 done, "result missing after transfer")

	// Commands cannot be taken while busy, so results never run together.
	`SCT_ASSERT(a_done_pulse, done |=> !done, "done held for more than one cycle")

	// Busy covers only the lookup cycle, which always moves on to the RMW cycle.
	`SCT_ASSERT(a_busy_single, busy |=> !busy, "busy held for more than one cycle")

	// A wake is only reported with a successful post result.
	`SCT_ASSERT(a_wake_ok, wake_valid |-> (done && status == ST_OK), "wake without ok result")

endmodule

bind counting_semaphore_table sct_checker u_sct_checker (.*);
